// File: hw/rtl/hswish_pkg.sv
package hswish_pkg;

   // Field widths
   localparam int SAMPLE_W    = 8;
   localparam int ZP_W        = 8;
   localparam int MULT_W      = 16;
   localparam int SHIFT_W     = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INPUT_ZERO_POINT  = 3'd0,
      REG_OUTPUT_ZERO_POINT = 3'd1,
      REG_INPUT_SCALE_MULT  = 3'd2,
      REG_RELUISH_MULT      = 3'd3,
      REG_OUTPUT_SCALE_MULT = 3'd4,
      REG_OUTPUT_SHIFT      = 3'd5
   } csr_reg_type;

endpackage

// File: hw/rtl/hswish_req_if.sv
interface hswish_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [hswish_pkg::SAMPLE_W-1:0]     sample;
   logic                                       last_in;

   modport source (output valid, output sample, output last_in, input ready);
   modport sink   (input valid, input sample, input last_in, output ready);
endinterface

// File: hw/rtl/hswish_rsp_if.sv
interface hswish_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [hswish_pkg::SAMPLE_W-1:0]     result;
   logic                                       last_out;

   modport source (output valid, output result, output last_out, input ready);
   modport sink   (input valid, input result, input last_out, output ready);
endinterface

// File: hw/rtl/hswish_csr_if.sv
interface hswish_csr_if;
   logic                                       valid;
   logic                                       ready;
   logic [hswish_pkg::CSR_INDEX_W-1:0]         index;
   logic [hswish_pkg::CSR_DATA_W-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/int8_hard_swish_fixed_point_unit.sv
// Quantized int8 hard-swish unit.
// Channels (valid/ready, a word moves when both are high on a rising edge):
//   req_bus : one signed 8-bit sample plus its last_in mark per word.
//   rsp_bus : one signed 8-bit result plus last_out, in request order.
//   csr_bus : register index and data; always ready, each write is registered when taken.
//             Write only while no words are in flight; unknown indexes are dropped.
// Throughput: one word per cycle, sustained while rsp_bus.ready stays high, set by the
//   seven-stage pipeline.
// Pipeline: a word accepted on req_bus passes seven register stages (offset/shift,
//   four multiply stages, power-of-two divide, zero-point add and clip) before it
//   is offered on rsp_bus.
// Stalls: each stage takes a new word when it is empty or its successor moves,
//   so bubbles are squeezed out; req_bus.ready drops only when all seven stages
//   hold words and rsp_bus.ready is low. Nothing is lost or repeated.
// Reset (synchronous, active high): empties the pipeline and clears every
//   configuration register to zero.
module int8_hard_swish_fixed_point_unit (
   input  logic         clock,
   input  logic         reset,
   hswish_req_if.sink   req_bus,
   hswish_rsp_if.source rsp_bus,
   hswish_csr_if.sink   csr_bus
);

   localparam int NUM_STAGES = 7;

   // ---------------------------------------------------------------------
   // Arithmetic helpers
   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Rounding doubling high multiply: floor((a*b + 2^14) / 2^15)
   function automatic logic signed [15:0] mul_round(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
      logic signed [31:0] p;
      logic signed [31:0] q;
      logic signed [15:0] r;
      p = a * b;
      q = (p + 32'sd16384) >>> 15;
      if (a == 16'sh8000 && b == 16'sh8000) begin
         r = 16'sh7fff;
      end else begin
         r = sat16({q[31], q});
      end
      return r;
   endfunction

   // Truncating doubling high multiply: a*b / 2^15 toward zero
   function automatic logic signed [15:0] mul_trunc(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
      logic signed [31:0] p;
      logic signed [31:0] q;
      logic signed [15:0] r;
      p = a * b;
      if (p < 0) begin
         q = (p + 32'sd32767) >>> 15;
      end else begin
         q = p >>> 15;
      end
      if (a == 16'sh8000 && b == 16'sh8000) begin
         r = 16'sh7fff;
      end else begin
         r = sat16({q[31], q});
      end
      return r;
   endfunction

   // Rounding divide by 2^e; negative e is a saturating left shift
   function automatic logic signed [15:0] div_pot(input logic signed [15:0] x,
                                                   input logic signed [4:0]  e);
      logic        [4:0]        lsh;
      logic        [3:0]        rsh;
      logic signed [32:0]       wide;
      logic        [15:0]       mask;
      logic        [15:0]       rem;
      logic        [15:0]       thr;
      logic signed [16:0]       q;
      logic signed [15:0]       r;
      lsh  = 5'(~e) + 5'd1;
      rsh  = e[3:0];
      wide = {{17{x[15]}}, x} <<< lsh;
      mask = 16'((17'd1 << rsh) - 17'd1);
      rem  = 16'(x) & mask;
      thr  = (mask >> 1) + {15'd0, x[15]};
      // floor shift must stay arithmetic, so both terms are signed
      q    = ($signed({x[15], x}) >>> rsh) + $signed({16'd0, (rem > thr)});
      if (e == 5'sd0) begin
         r = x;
      end else if (e[4]) begin
         r = sat16(wide);
      end else begin
         r = sat16({{16{q[16]}}, q});
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   logic signed [hswish_pkg::ZP_W-1:0]    in_zp_ff;
   logic signed [hswish_pkg::ZP_W-1:0]    out_zp_ff;
   logic signed [hswish_pkg::MULT_W-1:0]  in_mult_ff;
   logic signed [hswish_pkg::MULT_W-1:0]  relu_mult_ff;
   logic signed [hswish_pkg::MULT_W-1:0]  out_mult_ff;
   logic signed [hswish_pkg::SHIFT_W-1:0] out_shift_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_zp_ff     <= '0;
         out_zp_ff    <= '0;
         in_mult_ff   <= '0;
         relu_mult_ff <= '0;
         out_mult_ff  <= '0;
         out_shift_ff <= '0;
      end else if (csr_bus.valid) begin
         case (hswish_pkg::csr_reg_type'(csr_bus.index))
            hswish_pkg::REG_INPUT_ZERO_POINT:  in_zp_ff     <= csr_bus.data[7:0];
            hswish_pkg::REG_OUTPUT_ZERO_POINT: out_zp_ff    <= csr_bus.data[7:0];
            hswish_pkg::REG_INPUT_SCALE_MULT:  in_mult_ff   <= csr_bus.data;
            hswish_pkg::REG_RELUISH_MULT:      relu_mult_ff <= csr_bus.data;
            hswish_pkg::REG_OUTPUT_SCALE_MULT: out_mult_ff  <= csr_bus.data;
            hswish_pkg::REG_OUTPUT_SHIFT:      out_shift_ff <= csr_bus.data[4:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage loads when empty or when its successor moves
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] take;
   logic [NUM_STAGES-1:0] last_ff;

   always_comb begin
      take[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         take[k] = !vld_ff[k] || take[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (take[0]) begin
         vld_in[0] = req_bus.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (take[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   assign req_bus.ready = take[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // last mark travels with its word
   always_ff @(posedge clock) begin
      if (take[0]) begin
         last_ff[0] <= req_bus.last_in;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (take[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Data path
   logic signed [15:0] x_ff,      x_in;
   logic signed [15:0] scaled_ff, scaled_in;
   logic signed [15:0] rel_ff,    rel_in;
   logic signed [15:0] scaled2_ff;
   logic signed [15:0] prod_ff,   prod_in;
   logic signed [15:0] mr_ff,     mr_in;
   logic signed [15:0] o_ff,      o_in;
   logic signed [7:0]  res_ff,    res_in;
   logic signed [8:0]  diff;
   logic signed [16:0] sum;

   // Offset and shift by 7; |x| <= 255 so the shifted value fits int16
   assign diff = {req_bus.sample[7], req_bus.sample} - {in_zp_ff[7], in_zp_ff};
   assign x_in = {{7{diff[8]}}, diff} <<< 7;

   assign scaled_in = mul_round(x_ff, in_mult_ff);
   assign rel_in    = mul_round(scaled_ff, relu_mult_ff);
   assign prod_in   = mul_trunc(rel_ff, scaled2_ff);
   assign mr_in     = mul_round(prod_ff, out_mult_ff);
   assign o_in      = div_pot(mr_ff, out_shift_ff);

   // Zero-point add and int8 clip
   assign sum = {o_ff[15], o_ff} + {{9{out_zp_ff[7]}}, out_zp_ff};
   always_comb begin
      if (sum > 17'sd127) begin
         res_in = 8'sh7f;
      end else if (sum < -17'sd128) begin
         res_in = 8'sh80;
      end else begin
         res_in = sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         x_ff <= x_in;
      end
      if (take[1]) begin
         scaled_ff <= scaled_in;
      end
      if (take[2]) begin
         rel_ff     <= rel_in;
         scaled2_ff <= scaled_ff;
      end
      if (take[3]) begin
         prod_ff <= prod_in;
      end
      if (take[4]) begin
         mr_ff <= mr_in;
      end
      if (take[5]) begin
         o_ff <= o_in;
      end
      if (take[6]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid    = vld_ff[NUM_STAGES-1];
   assign rsp_bus.result   = res_ff;
   assign rsp_bus.last_out = last_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Checks
   // Input backs up only when every stage is full
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&vld_ff))
      else $error("request stalled while the pipeline has a bubble");

   // An accepted word occupies the first stage on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("accepted word lost at pipeline entry");

   // A full stage that cannot move keeps its word
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && !take[3]) |=> vld_ff[3])
      else $error("stalled stage dropped its word");

   // Reset leaves the pipeline empty
   assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
